// ----- hdl/brf_pkg.sv -----
// Package with shared codes, types and the mode-to-bank mapping of the banked register file.
package brf_pkg;

  localparam int BANK_COUNT = 6;
  localparam int LOW_COUNT = 8;
  localparam int MID_COUNT = 10;
  localparam int MID_FIQ_OFFSET = 5;

  localparam logic [1:0] CMD_READ = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;
  localparam logic [1:0] CMD_EXCEPTION = 2'd3;

  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  localparam logic [2:0] BANK_SHARED = 3'd0;
  localparam logic [2:0] BANK_FIQ = 3'd1;
  localparam logic [2:0] BANK_SVC = 3'd2;
  localparam logic [2:0] BANK_ABT = 3'd3;
  localparam logic [2:0] BANK_IRQ = 3'd4;
  localparam logic [2:0] BANK_UND = 3'd5;

  localparam logic [4:0] REG_FIRST_MID = 5'd8;
  localparam logic [4:0] REG_FIRST_STACK = 5'd13;
  localparam logic [4:0] REG_LINK = 5'd14;
  localparam logic [4:0] REG_PC = 5'd15;
  localparam logic [4:0] REG_SAVED_STATUS = 5'd16;

  localparam logic [2:0] EXC_RESET = 3'd0;
  localparam logic [2:0] EXC_UNDEF = 3'd1;
  localparam logic [2:0] EXC_SWI = 3'd2;
  localparam logic [2:0] EXC_PABT = 3'd3;
  localparam logic [2:0] EXC_DABT = 3'd4;
  localparam logic [2:0] EXC_ADDR26 = 3'd5;
  localparam logic [2:0] EXC_IRQ = 3'd6;
  localparam logic [2:0] EXC_FIQ = 3'd7;

  localparam logic [31:0] MODE_MASK = 32'h1F;
  localparam logic [31:0] THUMB_BIT = 32'h20;
  localparam logic [31:0] FIQ_MASK_BIT = 32'h40;
  localparam logic [31:0] IRQ_MASK_BIT = 32'h80;

  typedef enum logic [1:0] {
    LOC_NONE,
    LOC_REG,
    LOC_SAVED,
    LOC_PC
  } loc_t;

  function automatic logic [2:0] bank_of(input logic [4:0] mode);
    logic [2:0] bank;
    unique case (mode)
      MODE_FIQ: bank = BANK_FIQ;
      MODE_SVC: bank = BANK_SVC;
      MODE_ABT: bank = BANK_ABT;
      MODE_IRQ: bank = BANK_IRQ;
      MODE_UND: bank = BANK_UND;
      default: bank = BANK_SHARED;
    endcase
    return bank;
  endfunction

endpackage

// ----- hdl/brf_ram.sv -----
// Generic single-port-write, registered-read RAM.
module brf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/brf_decode.sv -----
// Register address decode: maps a mode and register number to a storage location.
module brf_decode #(
  parameter int BANK_COUNT = brf_pkg::BANK_COUNT,
  localparam int DEPTH_A = brf_pkg::LOW_COUNT + brf_pkg::MID_COUNT + 2 * BANK_COUNT,
  localparam int AW = $clog2(DEPTH_A),
  localparam int BW = $clog2(BANK_COUNT)
) (
  input  logic [4:0]    mode,
  input  logic [4:0]    reg_num,
  output brf_pkg::loc_t loc,
  output logic [AW-1:0] reg_addr,
  output logic [BW-1:0] bank
);

  localparam int MID_BASE = brf_pkg::LOW_COUNT;
  localparam int STACK_BASE = brf_pkg::LOW_COUNT + brf_pkg::MID_COUNT;

  logic [2:0]    bank_full;
  logic [AW-1:0] mid_offset;

  always_comb begin
    bank_full = brf_pkg::bank_of(mode);
    bank = bank_full[BW-1:0];
    mid_offset = (bank_full == brf_pkg::BANK_FIQ) ? AW'(brf_pkg::MID_FIQ_OFFSET) : '0;
    loc = brf_pkg::LOC_NONE;
    reg_addr = '0;
    priority if (reg_num < brf_pkg::REG_FIRST_MID) begin
      loc = brf_pkg::LOC_REG;
      reg_addr = AW'(reg_num);
    end else if (reg_num < brf_pkg::REG_FIRST_STACK) begin
      loc = brf_pkg::LOC_REG;
      reg_addr = AW'(MID_BASE) + mid_offset + AW'(reg_num - brf_pkg::REG_FIRST_MID);
    end else if (reg_num < brf_pkg::REG_PC) begin
      loc = brf_pkg::LOC_REG;
      reg_addr = AW'(STACK_BASE) + (AW'(bank) << 1)
               + AW'(reg_num - brf_pkg::REG_FIRST_STACK);
    end else if (reg_num == brf_pkg::REG_PC) begin
      loc = brf_pkg::LOC_PC;
    end else if (reg_num == brf_pkg::REG_SAVED_STATUS) begin
      loc = brf_pkg::LOC_SAVED;
    end else begin
      loc = brf_pkg::LOC_NONE;
    end
  end

endmodule

// ----- hdl/banked_register_file.sv -----
// Top level of the mode-banked register file with status word and exception entry.
//
//  Channel   Handshake              Payload
//  command   start / busy           in_command, in_mode_select, in_reg_select,
//                                   in_write_value, in_exception_kind, in_return_offset
//  result    out_strobe (1 cycle)   out_read_data, out_status_word, out_pc_value
//
// Each command is taken at a transfer and its result appears in the next cycle, when the
// registered read of the register or saved-status RAM returns; a new command may be taken every cycle.
// Writes go to the RAMs at the transfer edge, so a following read always sees them.
// busy is high while in reset and is cleared by the next clock edge; it stays low from then on.
// Reset clears the pc, the status word and the valid bits of both RAMs; an entry never
// written reads as zero. The receiver cannot stall the result.
module banked_register_file #(
  parameter int BANK_COUNT = brf_pkg::BANK_COUNT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [4:0]  in_mode_select,
  input  logic [4:0]  in_reg_select,
  input  logic [31:0] in_write_value,
  input  logic [2:0]  in_exception_kind,
  input  logic [3:0]  in_return_offset,
  output logic        out_strobe,
  output logic [31:0] out_read_data,
  output logic [31:0] out_status_word,
  output logic [31:0] out_pc_value
);

  localparam int DEPTH_A = brf_pkg::LOW_COUNT + brf_pkg::MID_COUNT + 2 * BANK_COUNT;
  localparam int AW = $clog2(DEPTH_A);
  localparam int BW = $clog2(BANK_COUNT);

  logic                accept;
  logic                is_read;
  logic                is_write;
  logic                is_exc;
  logic [4:0]          dec_reg;
  brf_pkg::loc_t       loc;
  logic [AW-1:0]       reg_addr;
  logic [BW-1:0]       bank;

  logic                we_a;
  logic [31:0]         wdata_a;
  logic [31:0]         rdata_a;
  logic                we_b;
  logic [31:0]         wdata_b;
  logic [31:0]         rdata_b;

  logic [DEPTH_A-1:0]    valid_a_r, valid_a_nxt;
  logic [BANK_COUNT-1:0] valid_b_r, valid_b_nxt;
  logic [31:0]           pc_r, pc_nxt;
  logic [31:0]           status_r, status_nxt;
  logic                  busy_r, busy_nxt;
  logic                  strobe_r, strobe_nxt;
  brf_pkg::loc_t         out_loc_r, out_loc_nxt;
  logic                  rd_valid_r, rd_valid_nxt;

  logic                  vec_hit;
  logic [31:0]           vec_addr;

  assign accept = start & ~busy_r;
  assign is_read = in_command == brf_pkg::CMD_READ;
  assign is_write = in_command == brf_pkg::CMD_WRITE;
  assign is_exc = in_command == brf_pkg::CMD_EXCEPTION;
  assign dec_reg = is_exc ? brf_pkg::REG_LINK : in_reg_select;

  brf_decode #(
    .BANK_COUNT(BANK_COUNT)
  ) u_decode (
    .mode    (in_mode_select),
    .reg_num (dec_reg),
    .loc     (loc),
    .reg_addr(reg_addr),
    .bank    (bank)
  );

  assign we_a = accept & ((is_write & (loc == brf_pkg::LOC_REG)) | is_exc);
  assign wdata_a = is_exc ? pc_r + 32'(in_return_offset) : in_write_value;
  assign we_b = accept & ((is_write & (loc == brf_pkg::LOC_SAVED)) | is_exc);
  assign wdata_b = is_exc ? status_r : in_write_value;

  brf_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH_A)
  ) u_reg_ram (
    .clk  (clk),
    .we   (we_a),
    .waddr(reg_addr),
    .wdata(wdata_a),
    .raddr(reg_addr),
    .rdata(rdata_a)
  );

  brf_ram #(
    .WIDTH(32),
    .DEPTH(BANK_COUNT)
  ) u_saved_ram (
    .clk  (clk),
    .we   (we_b),
    .waddr(bank),
    .wdata(wdata_b),
    .raddr(bank),
    .rdata(rdata_b)
  );

  always_comb begin
    vec_hit = 1'b0;
    vec_addr = '0;
    unique case (in_mode_select)
      brf_pkg::MODE_SVC: begin
        if (in_exception_kind == brf_pkg::EXC_RESET) begin
          vec_hit = 1'b1;
          vec_addr = 32'h0;
        end else if (in_exception_kind == brf_pkg::EXC_ADDR26) begin
          vec_hit = 1'b1;
          vec_addr = 32'h14;
        end else if (in_exception_kind == brf_pkg::EXC_SWI) begin
          vec_hit = 1'b1;
          vec_addr = 32'h8;
        end
      end
      brf_pkg::MODE_UND: begin
        if (in_exception_kind == brf_pkg::EXC_UNDEF) begin
          vec_hit = 1'b1;
          vec_addr = 32'h4;
        end
      end
      brf_pkg::MODE_ABT: begin
        if (in_exception_kind == brf_pkg::EXC_DABT) begin
          vec_hit = 1'b1;
          vec_addr = 32'h10;
        end else if (in_exception_kind == brf_pkg::EXC_PABT) begin
          vec_hit = 1'b1;
          vec_addr = 32'hC;
        end
      end
      brf_pkg::MODE_IRQ: begin
        if (in_exception_kind == brf_pkg::EXC_IRQ) begin
          vec_hit = 1'b1;
          vec_addr = 32'h18;
        end
      end
      brf_pkg::MODE_FIQ: begin
        if (in_exception_kind == brf_pkg::EXC_FIQ) begin
          vec_hit = 1'b1;
          vec_addr = 32'h1C;
        end
      end
      default: begin
        vec_hit = 1'b0;
      end
    endcase
  end

  always_comb begin
    pc_nxt = pc_r;
    status_nxt = status_r;
    valid_a_nxt = valid_a_r;
    valid_b_nxt = valid_b_r;
    busy_nxt = 1'b0;
    strobe_nxt = accept;
    out_loc_nxt = out_loc_r;
    rd_valid_nxt = rd_valid_r;
    if (accept) begin
      out_loc_nxt = is_read ? loc : brf_pkg::LOC_NONE;
      rd_valid_nxt = (loc == brf_pkg::LOC_SAVED) ? valid_b_r[bank] : valid_a_r[reg_addr];
      if (we_a) begin
        valid_a_nxt[reg_addr] = 1'b1;
      end
      if (we_b) begin
        valid_b_nxt[bank] = 1'b1;
      end
      if (is_write && (loc == brf_pkg::LOC_PC)) begin
        pc_nxt = in_write_value;
      end
      if (in_command == brf_pkg::CMD_STATUS) begin
        status_nxt = in_write_value;
      end
      if (is_exc) begin
        status_nxt = (status_r & ~(brf_pkg::THUMB_BIT | brf_pkg::MODE_MASK))
                   | 32'(in_mode_select) | brf_pkg::IRQ_MASK_BIT;
        if ((in_exception_kind == brf_pkg::EXC_RESET) ||
            (in_exception_kind == brf_pkg::EXC_FIQ)) begin
          status_nxt = status_nxt | brf_pkg::FIQ_MASK_BIT;
        end
        if (vec_hit) begin
          pc_nxt = vec_addr;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      status_r <= '0;
      valid_a_r <= '0;
      valid_b_r <= '0;
      busy_r <= 1'b1;
      strobe_r <= 1'b0;
      out_loc_r <= brf_pkg::LOC_NONE;
      rd_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      status_r <= status_nxt;
      valid_a_r <= valid_a_nxt;
      valid_b_r <= valid_b_nxt;
      busy_r <= busy_nxt;
      strobe_r <= strobe_nxt;
      out_loc_r <= out_loc_nxt;
      rd_valid_r <= rd_valid_nxt;
    end
  end

  always_comb begin
    unique case (out_loc_r)
      brf_pkg::LOC_REG: out_read_data = rd_valid_r ? rdata_a : '0;
      brf_pkg::LOC_SAVED: out_read_data = rd_valid_r ? rdata_b : '0;
      brf_pkg::LOC_PC: out_read_data = pc_r;
      default: out_read_data = '0;
    endcase
  end

  assign busy = busy_r;
  assign out_strobe = strobe_r;
  assign out_status_word = status_r;
  assign out_pc_value = pc_r;

endmodule

// ----- dv/banked_register_file_tb.sv -----
// Self-checking testbench for the banked register file: random and directed commands.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 200;
  localparam int RANDOM_PER_PHASE = 235;

  localparam logic [4:0] MODE_UNKNOWN = 5'h00;
  localparam logic [4:0] REG_R0 = 5'd0;
  localparam logic [4:0] REG_R7 = 5'd7;
  localparam logic [4:0] REG_R12 = 5'd12;
  localparam logic [4:0] REG_BEYOND = 5'd17;
  localparam logic [4:0] REG_TOP = 5'd31;

  localparam logic [31:0] VEC_RESET = 32'h00;
  localparam logic [31:0] VEC_UNDEF = 32'h04;
  localparam logic [31:0] VEC_SWI = 32'h08;
  localparam logic [31:0] VEC_PABT = 32'h0C;
  localparam logic [31:0] VEC_DABT = 32'h10;
  localparam logic [31:0] VEC_ADDR26 = 32'h14;
  localparam logic [31:0] VEC_IRQ = 32'h18;
  localparam logic [31:0] VEC_FIQ = 32'h1C;

  typedef struct {
    logic [1:0]  command;
    logic [4:0]  mode;
    logic [4:0]  sel;
    logic [31:0] value;
    logic [2:0]  kind;
    logic [3:0]  offset;
    int          gap_pct;
    bit          drain;
  } reg_cmd_t;

  typedef struct {
    logic [31:0] read_data;
    logic [31:0] status_word;
    logic [31:0] pc_value;
  } reg_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = '0;
  logic [4:0]  in_mode_select = '0;
  logic [4:0]  in_reg_select = '0;
  logic [31:0] in_write_value = '0;
  logic [2:0]  in_exception_kind = '0;
  logic [3:0]  in_return_offset = '0;
  logic        out_strobe;
  logic [31:0] out_read_data;
  logic [31:0] out_status_word;
  logic [31:0] out_pc_value;

  reg_cmd_t  pending_cmds[$];
  reg_view_t expected_views[$];
  reg_cmd_t  current_cmd;
  int        issued_count = 0;
  int        checked_count = 0;
  int        idle_cycles = 0;
  int        mismatches = 0;
  int        cmd_totals[4] = '{0, 0, 0, 0};
  int        vector_loads = 0;

  logic [31:0] shared_regs [brf_pkg::LOW_COUNT];
  logic [31:0] banked_mid [brf_pkg::MID_COUNT];
  logic [31:0] stack_link [2 * brf_pkg::BANK_COUNT];
  logic [31:0] saved_psr [brf_pkg::BANK_COUNT];
  logic [31:0] pc_reg = '0;
  logic [31:0] status_reg = '0;

  logic [4:0] valid_modes [7] = '{brf_pkg::MODE_USR, brf_pkg::MODE_FIQ, brf_pkg::MODE_IRQ,
                                  brf_pkg::MODE_SVC, brf_pkg::MODE_ABT, brf_pkg::MODE_UND,
                                  brf_pkg::MODE_SYS};
  logic [4:0] home_mode [8] = '{brf_pkg::MODE_SVC, brf_pkg::MODE_UND, brf_pkg::MODE_SVC,
                                brf_pkg::MODE_ABT, brf_pkg::MODE_ABT, brf_pkg::MODE_SVC,
                                brf_pkg::MODE_IRQ, brf_pkg::MODE_FIQ};

  banked_register_file i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_command(in_command),
    .in_mode_select(in_mode_select),
    .in_reg_select(in_reg_select),
    .in_write_value(in_write_value),
    .in_exception_kind(in_exception_kind),
    .in_return_offset(in_return_offset),
    .out_strobe(out_strobe),
    .out_read_data(out_read_data),
    .out_status_word(out_status_word),
    .out_pc_value(out_pc_value)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic reg_view_t apply_command(reg_cmd_t c);
    reg_view_t   v;
    logic [2:0]  bank;
    logic [31:0] vec;
    bit          hit;
    bit          wr;
    int          idx;
    case (c.mode)
      brf_pkg::MODE_FIQ: bank = brf_pkg::BANK_FIQ;
      brf_pkg::MODE_SVC: bank = brf_pkg::BANK_SVC;
      brf_pkg::MODE_ABT: bank = brf_pkg::BANK_ABT;
      brf_pkg::MODE_IRQ: bank = brf_pkg::BANK_IRQ;
      brf_pkg::MODE_UND: bank = brf_pkg::BANK_UND;
      default: bank = brf_pkg::BANK_SHARED;
    endcase
    wr = (c.command == brf_pkg::CMD_WRITE);
    v.read_data = '0;
    cmd_totals[c.command]++;
    case (c.command)
      brf_pkg::CMD_READ, brf_pkg::CMD_WRITE: begin
        if (c.sel < brf_pkg::REG_FIRST_MID) begin
          idx = int'(c.sel);
          v.read_data = shared_regs[idx];
          if (wr) shared_regs[idx] = c.value;
        end else if (c.sel < brf_pkg::REG_FIRST_STACK) begin
          idx = ((bank == brf_pkg::BANK_FIQ) ? brf_pkg::MID_FIQ_OFFSET : 0)
              + int'(c.sel) - int'(brf_pkg::REG_FIRST_MID);
          v.read_data = banked_mid[idx];
          if (wr) banked_mid[idx] = c.value;
        end else if (c.sel < brf_pkg::REG_PC) begin
          idx = int'(bank) * 2 + int'(c.sel) - int'(brf_pkg::REG_FIRST_STACK);
          v.read_data = stack_link[idx];
          if (wr) stack_link[idx] = c.value;
        end else if (c.sel == brf_pkg::REG_PC) begin
          v.read_data = pc_reg;
          if (wr) pc_reg = c.value;
        end else if (c.sel == brf_pkg::REG_SAVED_STATUS) begin
          v.read_data = saved_psr[bank];
          if (wr) saved_psr[bank] = c.value;
        end
        if (wr) v.read_data = '0;
      end
      brf_pkg::CMD_STATUS: begin
        status_reg = c.value;
      end
      default: begin
        stack_link[int'(bank) * 2 + 1] = pc_reg + 32'(c.offset);
        saved_psr[bank] = status_reg;
        status_reg = (status_reg & ~(brf_pkg::THUMB_BIT | brf_pkg::MODE_MASK))
                   | {27'd0, c.mode} | brf_pkg::IRQ_MASK_BIT;
        if (c.kind == brf_pkg::EXC_RESET || c.kind == brf_pkg::EXC_FIQ) begin
          status_reg |= brf_pkg::FIQ_MASK_BIT;
        end
        hit = 1'b1;
        vec = '0;
        case ({c.mode, c.kind})
          {brf_pkg::MODE_SVC, brf_pkg::EXC_RESET}: vec = VEC_RESET;
          {brf_pkg::MODE_SVC, brf_pkg::EXC_ADDR26}: vec = VEC_ADDR26;
          {brf_pkg::MODE_SVC, brf_pkg::EXC_SWI}: vec = VEC_SWI;
          {brf_pkg::MODE_UND, brf_pkg::EXC_UNDEF}: vec = VEC_UNDEF;
          {brf_pkg::MODE_ABT, brf_pkg::EXC_DABT}: vec = VEC_DABT;
          {brf_pkg::MODE_ABT, brf_pkg::EXC_PABT}: vec = VEC_PABT;
          {brf_pkg::MODE_IRQ, brf_pkg::EXC_IRQ}: vec = VEC_IRQ;
          {brf_pkg::MODE_FIQ, brf_pkg::EXC_FIQ}: vec = VEC_FIQ;
          default: hit = 1'b0;
        endcase
        if (hit) begin
          pc_reg = vec;
          vector_loads++;
        end
      end
    endcase
    v.status_word = status_reg;
    v.pc_value = pc_reg;
    return v;
  endfunction

  function automatic void push_directed(logic [1:0] command, logic [4:0] mode,
                                        logic [4:0] sel, logic [31:0] value,
                                        logic [2:0] kind, logic [3:0] offset);
    reg_cmd_t c;
    c.command = command;
    c.mode = mode;
    c.sel = sel;
    c.value = value;
    c.kind = kind;
    c.offset = offset;
    c.gap_pct = 18;
    c.drain = 1'b0;
    pending_cmds.push_back(c);
  endfunction

  function automatic reg_cmd_t random_cmd(int gap_pct);
    reg_cmd_t c;
    int       roll;
    roll = $urandom_range(99);
    c.command = roll < 35 ? brf_pkg::CMD_READ : roll < 65 ? brf_pkg::CMD_WRITE :
                roll < 75 ? brf_pkg::CMD_STATUS : brf_pkg::CMD_EXCEPTION;
    c.kind = 3'($urandom_range(7));
    c.offset = 4'($urandom_range(15));
    if ($urandom_range(9) < 2) begin
      c.mode = 5'($urandom_range(31));
    end else if (c.command == brf_pkg::CMD_EXCEPTION && $urandom_range(1) == 1) begin
      c.mode = home_mode[c.kind];
    end else begin
      c.mode = valid_modes[$urandom_range(6)];
    end
    c.sel = ($urandom_range(9) == 0) ? 5'($urandom_range(31, 17)) : 5'($urandom_range(16));
    roll = $urandom_range(9);
    c.value = roll == 0 ? 32'h0 : roll == 1 ? 32'hFFFF_FFFF : 32'($urandom());
    c.gap_pct = gap_pct;
    c.drain = 1'b0;
    return c;
  endfunction

  function automatic void check_field(string field, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : command_driver
    bit drained;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      drained = (issued_count == checked_count);
      if (start && !busy) begin
        expected_views.push_back(apply_command(current_cmd));
        issued_count <= issued_count + 1;
        drained = 1'b0;
      end
      if (!(start && busy)) begin
        if (pending_cmds.size() != 0 && !(pending_cmds[0].drain && !drained) &&
            $urandom_range(99) >= pending_cmds[0].gap_pct) begin
          current_cmd = pending_cmds.pop_front();
          in_command <= current_cmd.command;
          in_mode_select <= current_cmd.mode;
          in_reg_select <= current_cmd.sel;
          in_write_value <= current_cmd.value;
          in_exception_kind <= current_cmd.kind;
          in_return_offset <= current_cmd.offset;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    reg_view_t want;
    if (out_strobe) begin
      if (expected_views.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h %h %h", $time,
                 out_read_data, out_status_word, out_pc_value);
        mismatches++;
      end else begin
        want = expected_views.pop_front();
        checked_count <= checked_count + 1;
        check_field("read_data", out_read_data, want.read_data);
        check_field("status_word", out_status_word, want.status_word);
        check_field("pc_value", out_pc_value, want.pc_value);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int       gaps[3];
    reg_cmd_t c;
    gaps = '{18, 52, 0};
    foreach (shared_regs[i]) shared_regs[i] = '0;
    foreach (banked_mid[i]) banked_mid[i] = '0;
    foreach (stack_link[i]) stack_link[i] = '0;
    foreach (saved_psr[i]) saved_psr[i] = '0;

    push_directed(brf_pkg::CMD_READ, brf_pkg::MODE_USR, REG_R0, 32'h0,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_WRITE, brf_pkg::MODE_USR, REG_R0, 32'hFFFF_FFFF,
                  brf_pkg::EXC_FIQ, 4'd15);
    push_directed(brf_pkg::CMD_WRITE, brf_pkg::MODE_SYS, REG_R7, 32'h0,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_WRITE, brf_pkg::MODE_FIQ, brf_pkg::REG_FIRST_MID, 32'hA5A5_A5A5,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_WRITE, brf_pkg::MODE_USR, brf_pkg::REG_FIRST_MID, 32'h5A5A_5A5A,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_READ, brf_pkg::MODE_FIQ, brf_pkg::REG_FIRST_MID, 32'h0,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_READ, brf_pkg::MODE_IRQ, brf_pkg::REG_FIRST_MID, 32'h0,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_WRITE, brf_pkg::MODE_ABT, brf_pkg::REG_FIRST_STACK,
                  32'h1234_5678, brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_WRITE, MODE_UNKNOWN, REG_R12, 32'h8000_0001,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_READ, MODE_UNKNOWN, brf_pkg::REG_FIRST_STACK, 32'h0,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_WRITE, brf_pkg::MODE_SYS, brf_pkg::REG_SAVED_STATUS,
                  32'hFFFF_FFFF, brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_READ, brf_pkg::MODE_USR, brf_pkg::REG_SAVED_STATUS, 32'h0,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_WRITE, brf_pkg::MODE_USR, REG_BEYOND, 32'hDEAD_BEEF,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_READ, brf_pkg::MODE_USR, REG_TOP, 32'h0,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_STATUS, brf_pkg::MODE_USR, REG_R0, 32'hFFFF_FFFF,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_WRITE, brf_pkg::MODE_USR, brf_pkg::REG_PC, 32'hFFFF_FFF8,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_EXCEPTION, brf_pkg::MODE_SVC, REG_R0, 32'h0,
                  brf_pkg::EXC_RESET, 4'd15);
    pending_cmds[$].drain = 1'b1;
    push_directed(brf_pkg::CMD_EXCEPTION, brf_pkg::MODE_UND, REG_R0, 32'h0,
                  brf_pkg::EXC_UNDEF, 4'd4);
    push_directed(brf_pkg::CMD_EXCEPTION, brf_pkg::MODE_SVC, REG_R0, 32'h0,
                  brf_pkg::EXC_SWI, 4'd4);
    push_directed(brf_pkg::CMD_EXCEPTION, brf_pkg::MODE_ABT, REG_R0, 32'h0,
                  brf_pkg::EXC_PABT, 4'd4);
    push_directed(brf_pkg::CMD_EXCEPTION, brf_pkg::MODE_ABT, REG_R0, 32'h0,
                  brf_pkg::EXC_DABT, 4'd8);
    push_directed(brf_pkg::CMD_EXCEPTION, brf_pkg::MODE_SVC, REG_R0, 32'h0,
                  brf_pkg::EXC_ADDR26, 4'd0);
    push_directed(brf_pkg::CMD_EXCEPTION, brf_pkg::MODE_IRQ, REG_R0, 32'h0,
                  brf_pkg::EXC_IRQ, 4'd4);
    push_directed(brf_pkg::CMD_EXCEPTION, brf_pkg::MODE_FIQ, REG_R0, 32'h0,
                  brf_pkg::EXC_FIQ, 4'd4);
    push_directed(brf_pkg::CMD_EXCEPTION, brf_pkg::MODE_SVC, REG_R0, 32'h0,
                  brf_pkg::EXC_IRQ, 4'd2);
    push_directed(brf_pkg::CMD_READ, brf_pkg::MODE_SVC, brf_pkg::REG_LINK, 32'h0,
                  brf_pkg::EXC_RESET, 4'd0);
    push_directed(brf_pkg::CMD_READ, brf_pkg::MODE_FIQ, brf_pkg::REG_SAVED_STATUS, 32'h0,
                  brf_pkg::EXC_RESET, 4'd0);

    foreach (gaps[p]) begin
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        c = random_cmd(gaps[p]);
        c.drain = (i % 80 == 0);
        pending_cmds.push_back(c);
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0) @(posedge clk);
    while (start || issued_count != checked_count) @(posedge clk);
    repeat (4) @(posedge clk);
    if (expected_views.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_views.size());
      mismatches++;
    end

    $display("Checked %0d transfers: %0d reads, %0d writes, %0d status writes, %0d entries",
             checked_count, cmd_totals[brf_pkg::CMD_READ], cmd_totals[brf_pkg::CMD_WRITE],
             cmd_totals[brf_pkg::CMD_STATUS], cmd_totals[brf_pkg::CMD_EXCEPTION]);
    $display("Exception entries that loaded a vector: %0d, mismatches: %0d",
             vector_loads, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- banked_register_file.f -----
hdl/brf_pkg.sv
hdl/brf_ram.sv
hdl/brf_decode.sv
hdl/banked_register_file.sv
dv/banked_register_file_tb.sv
